// ===== src/assert_macros.svh =====
// Assertion macros shared by the sorter RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define HMS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled during reset.
`define HMS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define HMS_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define HMS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== src/hms_pkg.sv =====
// Types and constants for the hybrid merge insertion sorter.
// No dependencies; used by hms_cell and the top level.
package hms_pkg;

  localparam int VALUE_W = 32;

  // One storage slot of the sorting chain.
  typedef struct packed {
    logic                       vld;
    logic signed [VALUE_W-1:0]  val;
  } slot_t;

  // Per-cycle control broadcast to every cell.
  typedef struct packed {
    logic insert;  // a new value is placed into the ordered chain
    logic shift;   // the chain moves one slot toward cell zero
  } cell_ctl_t;

  // Block phase, one-hot.
  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage

// ===== src/hms_cell.sv =====
// One cell of the sorting chain: holds one slot of the ordered set.
// Depends on hms_pkg for the slot and control types.
module hms_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  hms_pkg::cell_ctl_t                   ctl,
  input  logic signed [hms_pkg::VALUE_W-1:0]   in_value,
  input  hms_pkg::slot_t                       prev_slot,
  input  logic                                 prev_takes,
  input  hms_pkg::slot_t                       next_slot,
  output hms_pkg::slot_t                       slot,
  output logic                                 takes
);

  hms_pkg::slot_t slot_next;

  // The new value belongs at or before this cell when the cell is empty
  // or holds a larger value.
  assign takes = !slot.vld || (slot.val > in_value);

  // On insert, a cell that yields either takes its left neighbor's slot
  // (which also yields) or the new value itself. On drain, take the right slot.
  always_comb begin
    slot_next = slot;
    if (ctl.shift) begin
      slot_next = next_slot;
    end else if (ctl.insert && takes) begin
      if (prev_takes) begin
        slot_next = prev_slot;
      end else begin
        slot_next.vld = 1'b1;
        slot_next.val = in_value;
      end
    end
  end

  // Valid bit is control state and resets; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot.vld <= 1'b0;
    end else begin
      slot.vld <= slot_next.vld;
    end
    slot.val <= slot_next.val;
  end

endmodule

// ===== src/hybrid_merge_insertion_sorter_unit.sv =====
// Hybrid merge insertion sorter: top level with the cell chain and phase control.
// Depends on hms_pkg, hms_cell and assert_macros.svh.
//
// Values enter on the s_ stream one transfer per cycle and are placed into
// sorted order on arrival by a chain of CAPACITY cells that all compare the
// new value at once and shift larger values one cell up. The transfer marked
// tlast closes the set; the block then stops taking input and sends the set
// in ascending order on the m_ stream, one transfer per cycle while m_tready
// is high, by shifting the chain toward cell zero. Values arriving while all
// CAPACITY cells are full are dropped and the overflow bit is set on every
// transfer of that set's output. There is no clearing pass after reset.
`include "assert_macros.svh"

module hybrid_merge_insertion_sorter_unit #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sorted_value
  output logic        m_tlast,   // end_of_run
  output logic [0:0]  m_tuser    // [0] overflow
);

  hms_pkg::state_t   state, state_next;
  logic              dropped, dropped_next;
  hms_pkg::cell_ctl_t ctl;
  hms_pkg::slot_t    slots [CAPACITY];
  logic              takes [CAPACITY];
  logic              in_xfer, out_xfer, full;

  assign s_tready = (state == hms_pkg::ST_LOAD);
  assign in_xfer  = s_tvalid && s_tready;
  assign m_tvalid = (state == hms_pkg::ST_DRAIN);
  assign out_xfer = m_tvalid && m_tready;
  assign full     = slots[CAPACITY-1].vld;

  assign ctl.insert = in_xfer && !full;
  assign ctl.shift  = out_xfer;

  // Chain of cells; the ends see an empty neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    hms_pkg::slot_t prev_slot, next_slot;
    logic           prev_takes;
    if (i == 0) begin : g_head
      assign prev_slot  = '0;
      assign prev_takes = 1'b0;
    end else begin : g_body
      assign prev_slot  = slots[i-1];
      assign prev_takes = takes[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_slot = '0;
    end else begin : g_inner
      assign next_slot = slots[i+1];
    end
    hms_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .in_value   (signed'(s_tdata)),
      .prev_slot  (prev_slot),
      .prev_takes (prev_takes),
      .next_slot  (next_slot),
      .slot       (slots[i]),
      .takes      (takes[i])
    );
  end

  // Output data comes straight from cell zero; tlast is set when cell one is empty.
  assign m_tdata    = unsigned'(slots[0].val);
  assign m_tlast    = !slots[1].vld;
  assign m_tuser[0] = dropped;

  // Phase control and overflow flag.
  always_comb begin
    state_next   = state;
    dropped_next = dropped;
    unique case (state)
      hms_pkg::ST_LOAD: begin
        if (in_xfer) begin
          if (full) begin
            dropped_next = 1'b1;
          end
          if (s_tlast) begin
            state_next = hms_pkg::ST_DRAIN;
          end
        end
      end
      hms_pkg::ST_DRAIN: begin
        if (out_xfer && m_tlast) begin
          state_next   = hms_pkg::ST_LOAD;
          dropped_next = 1'b0;
        end
      end
      default: begin
        state_next   = hms_pkg::ST_LOAD;
        dropped_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= hms_pkg::ST_LOAD;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      dropped <= dropped_next;
    end
  end

  // Output order is ascending along the chain.
  `HMS_ASSERT_IMPLY(a_sorted, clk, rst, m_tvalid && !m_tlast, slots[1].val >= slots[0].val)
  // Input and output phases never overlap.
  `HMS_ASSERT_IMPLY(a_phase, clk, rst, s_tready, !m_tvalid)
  // Closing a set always leaves at least one value to send.
  `HMS_ASSERT_NEXT(a_drain, clk, rst, in_xfer && s_tlast, m_tvalid && slots[0].vld)
  // The chain is empty once a run has been sent.
  `HMS_ASSERT_NEXT(a_empty, clk, rst, out_xfer && m_tlast, !slots[0].vld && !dropped)

endmodule
